### sv/basic_source_tokenizer_defines.svh
// assertion macros for the tokenizer
`ifndef BASIC_SOURCE_TOKENIZER_DEFINES_SVH
`define BASIC_SOURCE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define BST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BST_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define BST_ASSERT(lbl, clk, rst_n, prop, msg)
`define BST_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

### sv/bst_pkg.sv
package bst_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       source_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tok_char;
		logic       token_start;
		logic [2:0] token_kind;
	} out_item_t;

	typedef struct packed {
		logic is_nl;
		logic is_space;
		logic is_quote;
		logic is_dquote;
		logic is_lt;
		logic is_gt;
		logic is_eq;
		logic is_dot;
		logic is_digit;
		logic is_special;
	} char_class_t;

	typedef struct packed {
		logic      emit;
		out_item_t item;
	} scan_result_t;

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_COMPARE = 6'b000010,
		MODE_NUMBER  = 6'b000100,
		MODE_STRING  = 6'b001000,
		MODE_WORD    = 6'b010000,
		MODE_COMMENT = 6'b100000
	} scan_mode_t;

	localparam logic [2:0] KIND_NEWLINE = 3'd0;
	localparam logic [2:0] KIND_COMPARE = 3'd1;
	localparam logic [2:0] KIND_NUMBER  = 3'd2;
	localparam logic [2:0] KIND_SPECIAL = 3'd3;
	localparam logic [2:0] KIND_STRING  = 3'd4;
	localparam logic [2:0] KIND_WORD    = 3'd5;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_DOT    = 8'h2E;

endpackage

### sv/bst_classify.sv
module bst_classify (
	input  logic [7:0]           ch,
	output bst_pkg::char_class_t cls
);
	import bst_pkg::*;

	always_comb begin
		cls.is_nl      = (ch == CH_NL);
		cls.is_space   = (ch == CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0D);
		cls.is_quote   = (ch == CH_QUOTE);
		cls.is_dquote  = (ch == CH_DQUOTE);
		cls.is_lt      = (ch == CH_LT);
		cls.is_gt      = (ch == CH_GT);
		cls.is_eq      = (ch == CH_EQ);
		cls.is_dot     = (ch == CH_DOT);
		cls.is_digit   = (ch >= 8'h30) && (ch <= 8'h39);
		// ( ) [ ] < > + - / * = . ' , :
		cls.is_special = (ch == 8'h28) || (ch == 8'h29) || (ch == 8'h5B) || (ch == 8'h5D)
			|| (ch == CH_LT) || (ch == CH_GT) || (ch == 8'h2B) || (ch == 8'h2D)
			|| (ch == 8'h2F) || (ch == 8'h2A) || (ch == CH_EQ) || (ch == CH_DOT)
			|| (ch == CH_QUOTE) || (ch == 8'h2C) || (ch == 8'h3A);
	end

endmodule

### sv/bst_scan.sv
`include "basic_source_tokenizer_defines.svh"

module bst_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  bst_pkg::in_item_t     item,
	input  bst_pkg::char_class_t  cls,
	output bst_pkg::scan_result_t result
);
	import bst_pkg::*;

	scan_mode_t mode_q, mode_n;
	logic       dot_q, dot_n;
	logic       lt_q, lt_n;
	logic       nl_q, nl_n;
	logic       done;

	always_comb begin
		mode_n = mode_q;
		dot_n  = dot_q;
		lt_n   = lt_q;
		nl_n   = nl_q;
		done   = 1'b0;
		result.emit             = 1'b0;
		result.item.tok_char    = item.ch;
		result.item.token_start = 1'b0;
		result.item.token_kind  = KIND_WORD;

		// continue an open token
		unique case (mode_q)
			MODE_COMPARE: begin
				mode_n = MODE_IDLE;
				lt_n   = 1'b0;
				if (cls.is_eq || (lt_q && cls.is_gt)) begin
					result.emit            = 1'b1;
					result.item.token_kind = KIND_COMPARE;
					done                   = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (cls.is_digit || (!dot_q && cls.is_dot)) begin
					if (cls.is_dot) begin
						dot_n = 1'b1;
					end
					result.emit            = 1'b1;
					result.item.token_kind = KIND_NUMBER;
					done                   = 1'b1;
				end else begin
					mode_n = MODE_IDLE;
					dot_n  = 1'b0;
				end
			end
			MODE_STRING: begin
				if (cls.is_nl) begin
					mode_n = MODE_IDLE;
				end else begin
					if (cls.is_dquote) begin
						mode_n = MODE_IDLE;
					end
					result.emit            = 1'b1;
					result.item.token_kind = KIND_STRING;
					done                   = 1'b1;
				end
			end
			MODE_WORD: begin
				if (!cls.is_special && !cls.is_space) begin
					result.emit            = 1'b1;
					result.item.token_kind = KIND_WORD;
					done                   = 1'b1;
				end else begin
					mode_n = MODE_IDLE;
				end
			end
			MODE_COMMENT: begin
				if (cls.is_nl) begin
					mode_n = MODE_IDLE;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		// start a new token
		if (!done) begin
			priority if (cls.is_nl) begin
				if (!nl_q) begin
					nl_n                    = 1'b1;
					result.emit             = 1'b1;
					result.item.token_start = 1'b1;
					result.item.token_kind  = KIND_NEWLINE;
				end
			end else if (cls.is_space) begin
				nl_n = nl_q;
			end else if (cls.is_quote) begin
				mode_n = MODE_COMMENT;
			end else begin
				nl_n                    = 1'b0;
				result.emit             = 1'b1;
				result.item.token_start = 1'b1;
				priority if (cls.is_lt || cls.is_gt) begin
					mode_n                 = MODE_COMPARE;
					lt_n                   = cls.is_lt;
					result.item.token_kind = KIND_COMPARE;
				end else if (cls.is_digit) begin
					mode_n                 = MODE_NUMBER;
					dot_n                  = 1'b0;
					result.item.token_kind = KIND_NUMBER;
				end else if (cls.is_special) begin
					result.item.token_kind = KIND_SPECIAL;
				end else if (cls.is_dquote) begin
					mode_n                 = MODE_STRING;
					result.item.token_kind = KIND_STRING;
				end else begin
					mode_n                 = MODE_WORD;
					result.item.token_kind = KIND_WORD;
				end
			end
		end

		if (item.source_last) begin
			mode_n = MODE_IDLE;
			dot_n  = 1'b0;
			lt_n   = 1'b0;
			nl_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dot_q  <= 1'b0;
			lt_q   <= 1'b0;
			nl_q   <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_n;
			dot_q  <= dot_n;
			lt_q   <= lt_n;
			nl_q   <= nl_n;
		end
	end

	`BST_ASSERT(a_last_resets, clk, arst_n,
		advance && item.source_last |=> mode_q == MODE_IDLE && !nl_q && !dot_q && !lt_q,
		"state not cleared after last byte")
	`BST_ASSERT(a_dot_in_number, clk, arst_n, dot_q |-> mode_q == MODE_NUMBER,
		"dot flag outside number")
	`BST_ASSERT(a_lt_in_compare, clk, arst_n, lt_q |-> mode_q == MODE_COMPARE,
		"less-than flag outside compare")

endmodule

### sv/basic_source_tokenizer.sv
// basic_source_tokenizer: splits a source byte stream into marked token bytes
//
// in channel (in_valid/in_ready/in_item): one source byte per transfer, with
// source_last set on the final byte of a text.
// out channel (out_valid/out_ready/out_item): zero or one result per byte,
// each a kept byte with token_start and token_kind.
//
// a byte is decoded against the scan state while it sits in the input
// register, and its result is then captured in the output register once
// that is free. one byte per cycle is sustained while the receiver does not
// stall; the scan state update is the loop that sets this.
// when the receiver stalls, the held result stays put and the input register
// still takes one more byte; in_ready then drops until the result leaves.
// reset clears both valid flags and the scan state; after a byte with
// source_last the scan state returns to its reset value.
`include "basic_source_tokenizer_defines.svh"

module basic_source_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bst_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bst_pkg::out_item_t out_item
);
	import bst_pkg::*;

	logic         valid_s1;
	in_item_t     item_s1;
	logic         advance;
	char_class_t  cls;
	scan_result_t result;
	logic         out_valid_q;
	out_item_t    out_item_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	bst_classify u_classify (
		.ch  (item_s1.ch),
		.cls (cls)
	);

	bst_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cls     (cls),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			out_item_q <= result.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`BST_ASSERT(a_ready_when_empty, clk, arst_n, !out_valid_q |-> in_ready,
		"input blocked with empty output")
	`BST_ASSERT(a_newline_form, clk, arst_n,
		out_valid_q && out_item_q.token_kind == KIND_NEWLINE
			|-> out_item_q.token_start && out_item_q.tok_char == CH_NL,
		"malformed newline token")
	`BST_ASSERT_NEVER(a_no_cont_single, clk, arst_n,
		out_valid_q && !out_item_q.token_start
			&& (out_item_q.token_kind == KIND_NEWLINE || out_item_q.token_kind == KIND_SPECIAL),
		"continuation of a single-byte token")

endmodule
